// File: rtl/core/rbfk_pkg.sv
// Shared constants, codes and constant-divisor helpers for the RBF kernel block.
// No dependencies; used by every module in rtl/core.
package rbfk_pkg;

    localparam int unsigned FIELD_W   = 32;
    localparam int unsigned IDX_W     = 8;
    localparam int unsigned DATA_W    = 48;
    localparam int unsigned USER_W    = 3;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned DIM_W     = 9;

    localparam logic [1:0] KT_GAUSS  = 2'd0;
    localparam logic [1:0] KT_MQUAD  = 2'd1;
    localparam logic [1:0] KT_TPS    = 2'd2;
    localparam logic [1:0] KT_BYPASS = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_ZERO    = 2'd2;
    localparam logic [1:0] ST_SAT     = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_TYPE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMMETRIC   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS        = 3'd4;

    localparam logic [30:0] Q30_ONE  = 31'h4000_0000;
    localparam logic [28:0] E1_Q30   = 29'd395007542;
    localparam logic [29:0] LN2_Q30  = 30'd744261118;
    localparam logic [31:0] POS_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_MAX  = 32'h8000_0000;

    localparam int unsigned TAYLOR_TERMS = 13;
    localparam int unsigned E1_STEPS     = 11;
    localparam int unsigned SQRT_STEPS   = 32;
    localparam int unsigned DIV_STEPS    = 30;
    localparam int unsigned LN_TERMS     = 11;

    localparam int unsigned GAUSS_LAT = 42;
    localparam int unsigned MQ_LAT    = 35;
    localparam int unsigned TPS_LAT   = 59;
    localparam int unsigned PIPE_LAT  = TPS_LAT;

    // ceil(2^35 / k), exact floor division for dividends below 2^30
    function automatic logic [35:0] recip(input int unsigned k);
        logic [35:0] m;
        case (k)
            1:  m = 36'd34359738368;
            2:  m = 36'd17179869184;
            3:  m = 36'd11453246123;
            4:  m = 36'd8589934592;
            5:  m = 36'd6871947674;
            6:  m = 36'd5726623062;
            7:  m = 36'd4908534053;
            8:  m = 36'd4294967296;
            9:  m = 36'd3817748708;
            10: m = 36'd3435973837;
            11: m = 36'd3123612579;
            12: m = 36'd2863311531;
            13: m = 36'd2643056798;
            15: m = 36'd2290649225;
            17: m = 36'd2021161081;
            19: m = 36'd1808407283;
            21: m = 36'd1636178018;
            23: m = 36'd1493901669;
            default: m = '0;
        endcase
        return m;
    endfunction

    function automatic logic [29:0] div_small(input logic [29:0] a, input int unsigned k);
        logic [65:0] p;
        p = 66'(a) * 66'(recip(k));
        return p[64:35];
    endfunction

endpackage

// File: rtl/core/rbfk_gauss.sv
// Gaussian kernel path: exp(-beta*v^2) in Q.30 (output rounded to Q16.16), Taylor series plus e^-1 steps.
// Depends on rbfk_pkg.
module rbfk_gauss (
    input  logic        i_clk,
    input  logic        i_ce,
    input  logic [31:0] i_mag,
    input  logic [31:0] i_beta,
    output logic [31:0] o_value,
    output logic [1:0]  o_status
);
    localparam int unsigned NT = rbfk_pkg::TAYLOR_TERMS;
    localparam int unsigned NE = rbfk_pkg::E1_STEPS;

    logic [63:0] r_v2;
    logic [63:0] r_ph;
    logic [63:0] r_pl;
    logic [95:0] w_full;

    logic [30:0]        r_b_term [0:NT];
    logic signed [33:0] r_b_sum  [0:NT];
    logic [29:0]        r_b_f    [0:NT];
    logic [3:0]         r_b_n    [0:NT];
    logic               r_b_big  [0:NT];

    logic [29:0]        r_a_prod [1:NT];
    logic signed [33:0] r_a_sum  [1:NT];
    logic [29:0]        r_a_f    [1:NT];
    logic [3:0]         r_a_n    [1:NT];
    logic               r_a_big  [1:NT];

    logic [60:0] w_mul [1:NT];
    logic [29:0] w_div [1:NT];

    logic [30:0] r_e   [0:NE];
    logic [3:0]  r_en  [0:NE];
    logic        r_ebig[0:NE];
    logic [61:0] w_emul[1:NE];
    logic [31:0] w_rnd;

    assign w_full = {r_ph, 32'b0} + {32'b0, r_pl};
    assign w_rnd  = 32'(r_e[NE]) + 32'd8192;

    always_comb begin
        for (int k = 1; k <= NT; k++) begin
            w_mul[k] = 61'(r_b_term[k-1]) * 61'(r_b_f[k-1]);
            w_div[k] = rbfk_pkg::div_small(r_a_prod[k], k);
        end
        for (int i = 1; i <= NE; i++) begin
            w_emul[i] = 62'(r_e[i-1]) * 62'(rbfk_pkg::E1_Q30);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_v2 <= 64'(i_mag) * 64'(i_mag);
            r_ph <= 64'(r_v2[63:32]) * 64'(i_beta);
            r_pl <= 64'(r_v2[31:0]) * 64'(i_beta);

            r_b_term[0] <= rbfk_pkg::Q30_ONE;
            r_b_sum[0]  <= 34'(rbfk_pkg::Q30_ONE);
            r_b_f[0]    <= w_full[47:18];
            r_b_n[0]    <= w_full[51:48];
            r_b_big[0]  <= (w_full[95:48] >= 48'd12);

            for (int k = 1; k <= NT; k++) begin
                r_a_prod[k] <= w_mul[k][59:30];
                r_a_sum[k]  <= r_b_sum[k-1];
                r_a_f[k]    <= r_b_f[k-1];
                r_a_n[k]    <= r_b_n[k-1];
                r_a_big[k]  <= r_b_big[k-1];

                r_b_term[k] <= 31'(w_div[k]);
                if ((k & 1) == 1) begin
                    r_b_sum[k] <= r_a_sum[k] - $signed(34'(w_div[k]));
                end else begin
                    r_b_sum[k] <= r_a_sum[k] + $signed(34'(w_div[k]));
                end
                r_b_f[k]   <= r_a_f[k];
                r_b_n[k]   <= r_a_n[k];
                r_b_big[k] <= r_a_big[k];
            end

            r_e[0]    <= r_b_sum[NT][33] ? 31'd0 : r_b_sum[NT][30:0];
            r_en[0]   <= r_b_n[NT];
            r_ebig[0] <= r_b_big[NT];
            for (int i = 1; i <= NE; i++) begin
                r_e[i]    <= (4'(i - 1) < r_en[i-1]) ? w_emul[i][60:30] : r_e[i-1];
                r_en[i]   <= r_en[i-1];
                r_ebig[i] <= r_ebig[i-1];
            end

            if (r_ebig[NE] || (w_rnd[31:14] == 18'd0)) begin
                o_value  <= '0;
                o_status <= rbfk_pkg::ST_ZERO;
            end else begin
                o_value  <= 32'(w_rnd[31:14]);
                o_status <= rbfk_pkg::ST_OK;
            end
        end
    end

endmodule

// File: rtl/core/rbfk_mq.sv
// Multiquadratic kernel path: sqrt(v^2+beta^2), one root bit per stage.
// Depends on rbfk_pkg.
module rbfk_mq (
    input  logic        i_clk,
    input  logic        i_ce,
    input  logic [31:0] i_mag,
    input  logic [31:0] i_beta,
    output logic [31:0] o_value,
    output logic [1:0]  o_status
);
    localparam int unsigned NS = rbfk_pkg::SQRT_STEPS;

    logic [63:0] r_v2;
    logic [63:0] r_b2;
    logic        r_bsat0;

    logic [63:0] r_x   [0:NS];
    logic [63:0] r_r   [0:NS];
    logic        r_sat [0:NS];
    logic [63:0] w_rb  [1:NS];
    logic [63:0] w_root;

    always_comb begin
        for (int j = 1; j <= NS; j++) begin
            w_rb[j] = r_r[j-1] + (64'd1 << (64 - 2 * j));
        end
    end

    assign w_root = r_r[NS] + 64'(r_x[NS] > r_r[NS]);

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_v2    <= 64'(i_mag) * 64'(i_mag);
            r_b2    <= 64'(i_beta[30:0]) * 64'(i_beta[30:0]);
            r_bsat0 <= i_beta[31];

            r_x[0]   <= r_v2 + r_b2;
            r_r[0]   <= '0;
            r_sat[0] <= r_bsat0;

            for (int j = 1; j <= NS; j++) begin
                if (r_x[j-1] >= w_rb[j]) begin
                    r_x[j] <= r_x[j-1] - w_rb[j];
                    r_r[j] <= (r_r[j-1] >> 1) + (64'd1 << (64 - 2 * j));
                end else begin
                    r_x[j] <= r_x[j-1];
                    r_r[j] <= r_r[j-1] >> 1;
                end
                r_sat[j] <= r_sat[j-1];
            end

            if (r_sat[NS] || (w_root > 64'(rbfk_pkg::POS_MAX))) begin
                o_value  <= rbfk_pkg::POS_MAX;
                o_status <= rbfk_pkg::ST_SAT;
            end else begin
                o_value  <= w_root[31:0];
                o_status <= (w_root == 64'd0) ? rbfk_pkg::ST_ZERO : rbfk_pkg::ST_OK;
            end
        end
    end

endmodule

// File: rtl/core/rbfk_tps.sv
// Thin plate spline path: v^2*ln(v) with a bit-per-stage divider and log series.
// Depends on rbfk_pkg.
module rbfk_tps (
    input  logic        i_clk,
    input  logic        i_ce,
    input  logic [31:0] i_raw,
    output logic [31:0] o_value,
    output logic [1:0]  o_status
);
    localparam int unsigned ND = rbfk_pkg::DIV_STEPS;
    localparam int unsigned NL = rbfk_pkg::LN_TERMS;

    logic [4:0]  w_p;
    logic [30:0] w_m;

    logic [31:0] r_rem [0:ND];
    logic [31:0] r_d   [0:ND];
    logic [29:0] r_q   [0:ND];
    logic [4:0]  r_dp  [0:ND];
    logic [30:0] r_draw[0:ND];
    logic        r_dbad[0:ND];
    logic [32:0] w_rem2[1:ND];

    logic [29:0] r_sb_term[0:NL];
    logic [30:0] r_sb_sum [0:NL];
    logic [29:0] r_sb_z2  [0:NL];
    logic [4:0]  r_sb_p   [0:NL];
    logic [30:0] r_sb_raw [0:NL];
    logic        r_sb_bad [0:NL];

    logic [29:0] r_sa_term[1:NL];
    logic [30:0] r_sa_sum [1:NL];
    logic [29:0] r_sa_z2  [1:NL];
    logic [4:0]  r_sa_p   [1:NL];
    logic [30:0] r_sa_raw [1:NL];
    logic        r_sa_bad [1:NL];

    logic [59:0] w_tm  [1:NL];
    logic [59:0] w_zz;

    logic signed [5:0]  w_pm;
    logic signed [36:0] w_l;
    logic signed [36:0] r_l;
    logic [63:0]        r_v2a;
    logic               r_bad_l;
    logic [33:0]        r_lm;
    logic               r_lneg;
    logic [63:0]        r_v2b;
    logic               r_bad_m;
    logic [63:0]        r_pll;
    logic [63:0]        r_plh;
    logic [63:0]        r_phl;
    logic [63:0]        r_phh;
    logic               r_lneg_p;
    logic               r_bad_p;
    logic [95:0]        r_prod;
    logic               r_lneg_s;
    logic               r_bad_s;
    logic [96:0]        w_t;
    logic [50:0]        w_r;

    always_comb begin
        w_p = '0;
        for (int b = 0; b < 31; b++) begin
            if (i_raw[b]) begin
                w_p = 5'(b);
            end
        end
        w_m = 31'(i_raw[30:0] << (5'd30 - w_p));
        for (int j = 1; j <= ND; j++) begin
            w_rem2[j] = {r_rem[j-1], 1'b0};
        end
        for (int k = 1; k <= NL; k++) begin
            w_tm[k] = 60'(r_sb_term[k-1]) * 60'(r_sb_z2[k-1]);
        end
    end

    assign w_zz = 60'(r_q[ND]) * 60'(r_q[ND]);
    assign w_pm = $signed({1'b0, r_sb_p[NL]}) - 6'sd16;
    assign w_l  = 37'(w_pm) * $signed(37'(rbfk_pkg::LN2_Q30))
                + $signed({5'b0, r_sb_sum[NL], 1'b0});
    assign w_t  = {1'b0, r_prod} + (97'd1 << 45);
    assign w_r  = w_t[96:46];

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_rem[0]  <= 32'(w_m - rbfk_pkg::Q30_ONE);
            r_d[0]    <= 32'(w_m) + 32'(rbfk_pkg::Q30_ONE);
            r_q[0]    <= '0;
            r_dp[0]   <= w_p;
            r_draw[0] <= i_raw[30:0];
            r_dbad[0] <= i_raw[31] || (i_raw == 32'd0);

            for (int j = 1; j <= ND; j++) begin
                if (w_rem2[j] >= {1'b0, r_d[j-1]}) begin
                    r_rem[j] <= 32'(w_rem2[j] - {1'b0, r_d[j-1]});
                    r_q[j]   <= {r_q[j-1][28:0], 1'b1};
                end else begin
                    r_rem[j] <= w_rem2[j][31:0];
                    r_q[j]   <= {r_q[j-1][28:0], 1'b0};
                end
                r_d[j]    <= r_d[j-1];
                r_dp[j]   <= r_dp[j-1];
                r_draw[j] <= r_draw[j-1];
                r_dbad[j] <= r_dbad[j-1];
            end

            r_sb_term[0] <= r_q[ND];
            r_sb_sum[0]  <= 31'(r_q[ND]);
            r_sb_z2[0]   <= w_zz[59:30];
            r_sb_p[0]    <= r_dp[ND];
            r_sb_raw[0]  <= r_draw[ND];
            r_sb_bad[0]  <= r_dbad[ND];

            for (int k = 1; k <= NL; k++) begin
                r_sa_term[k] <= w_tm[k][59:30];
                r_sa_sum[k]  <= r_sb_sum[k-1];
                r_sa_z2[k]   <= r_sb_z2[k-1];
                r_sa_p[k]    <= r_sb_p[k-1];
                r_sa_raw[k]  <= r_sb_raw[k-1];
                r_sa_bad[k]  <= r_sb_bad[k-1];

                r_sb_term[k] <= r_sa_term[k];
                r_sb_sum[k]  <= r_sa_sum[k]
                              + 31'(rbfk_pkg::div_small(r_sa_term[k], 2 * k + 1));
                r_sb_z2[k]   <= r_sa_z2[k];
                r_sb_p[k]    <= r_sa_p[k];
                r_sb_raw[k]  <= r_sa_raw[k];
                r_sb_bad[k]  <= r_sa_bad[k];
            end

            r_l     <= w_l;
            r_v2a   <= 64'(r_sb_raw[NL]) * 64'(r_sb_raw[NL]);
            r_bad_l <= r_sb_bad[NL];

            r_lneg  <= r_l[36];
            r_lm    <= r_l[36] ? 34'(-r_l) : r_l[33:0];
            r_v2b   <= r_v2a;
            r_bad_m <= r_bad_l;

            r_pll    <= 64'(r_v2b[31:0])  * 64'(r_lm[31:0]);
            r_plh    <= 64'(r_v2b[31:0])  * 64'(r_lm[33:32]);
            r_phl    <= 64'(r_v2b[61:32]) * 64'(r_lm[31:0]);
            r_phh    <= 64'(r_v2b[61:32]) * 64'(r_lm[33:32]);
            r_lneg_p <= r_lneg;
            r_bad_p  <= r_bad_m;

            r_prod   <= 96'(r_pll) + ((96'(r_plh) + 96'(r_phl)) << 32)
                      + (96'(r_phh) << 64);
            r_lneg_s <= r_lneg_p;
            r_bad_s  <= r_bad_p;

            if (r_bad_s) begin
                o_value  <= '0;
                o_status <= rbfk_pkg::ST_INVALID;
            end else if (r_lneg_s) begin
                if (w_r > 51'h8000_0000) begin
                    o_value  <= rbfk_pkg::NEG_MAX;
                    o_status <= rbfk_pkg::ST_SAT;
                end else begin
                    o_value  <= 32'(-w_r);
                    o_status <= (w_r == 51'd0) ? rbfk_pkg::ST_ZERO : rbfk_pkg::ST_OK;
                end
            end else if (w_r > 51'(rbfk_pkg::POS_MAX)) begin
                o_value  <= rbfk_pkg::POS_MAX;
                o_status <= rbfk_pkg::ST_SAT;
            end else begin
                o_value  <= w_r[31:0];
                o_status <= (w_r == 51'd0) ? rbfk_pkg::ST_ZERO : rbfk_pkg::ST_OK;
            end
        end
    end

endmodule

// File: rtl/core/rbf_kernel_elementwise.sv
// Top level of the element-wise radial basis kernel: config registers, window check,
// alignment of the three kernel paths and the output register. Uses rbfk_pkg,
// rbfk_gauss, rbfk_mq and rbfk_tps.
//
// Usage: one matrix element per s-side transfer (value, row, column in tdata). The
// element passes through a 59-stage pipeline that evaluates all kernels; the one
// selected by kernel_type is placed in the m-side output register, with row,
// column, mirror flag and status. Elements outside the matrix, or outside the
// upper triangle in symmetric mode, give no m-side transfer.
// tvalid comes from the m-side output register behind the last pipeline stage.
// Throughput: one element per cycle unless held by a stall; the thin plate
// spline path (30-step divider and 11-term log series) sets the pipeline depth.
// Config: cfg port always ready; write only while the pipeline is empty.
// Reset (i_rst_n low, synchronous) empties the pipeline and restores register
// defaults. When the receiver stalls, the pipeline keeps filling its empty
// slots; it holds as soon as the oldest result is blocked.
module rbf_kernel_elementwise #(
    parameter int MAX_DIM = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [rbfk_pkg::DATA_W-1:0]    i_s_tdata,  // elem_value, row_index, col_index
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [rbfk_pkg::DATA_W-1:0]    o_m_tdata,  // kernel_value, out_row, out_col
    output logic [rbfk_pkg::USER_W-1:0]    o_m_tuser,  // mirror_too, result_status
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rbfk_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                    i_cfg_data
);
    localparam int unsigned LAT  = rbfk_pkg::PIPE_LAT;
    localparam int unsigned GPAD = rbfk_pkg::PIPE_LAT - rbfk_pkg::GAUSS_LAT;
    localparam int unsigned MPAD = rbfk_pkg::PIPE_LAT - rbfk_pkg::MQ_LAT;
    localparam int          DW0  = $clog2(MAX_DIM + 1);
    localparam int          CW   = (DW0 > 9) ? DW0 : 9;
    localparam logic [CW-1:0] LIM = CW'(MAX_DIM);

    logic [1:0]  r_kernel_type;
    logic [31:0] r_beta;
    logic        r_sym;
    logic [8:0]  r_rows;
    logic [8:0]  r_cols;

    logic [31:0] w_raw;
    logic [7:0]  w_row;
    logic [7:0]  w_col;
    logic [31:0] w_mag;
    logic [CW-1:0] w_rows;
    logic [CW-1:0] w_cols;
    logic [CW-1:0] w_n;
    logic        w_pass;
    logic        w_out_free;
    logic        w_ce;

    logic        r_vld [0:LAT-1];
    logic [7:0]  r_row [0:LAT-1];
    logic [7:0]  r_col [0:LAT-1];
    logic [31:0] r_raw [0:LAT-1];

    logic [31:0] w_g_val;
    logic [1:0]  w_g_st;
    logic [31:0] w_m_val;
    logic [1:0]  w_m_st;
    logic [31:0] w_t_val;
    logic [1:0]  w_t_st;
    logic [31:0] r_gpad_val [0:GPAD-1];
    logic [1:0]  r_gpad_st  [0:GPAD-1];
    logic [31:0] r_mpad_val [0:MPAD-1];
    logic [1:0]  r_mpad_st  [0:MPAD-1];

    logic [31:0] w_sel_val;
    logic [1:0]  w_sel_st;
    logic        r_out_vld;
    logic [31:0] r_out_val;
    logic [7:0]  r_out_row;
    logic [7:0]  r_out_col;
    logic        r_out_mir;
    logic [1:0]  r_out_st;

    assign w_raw  = i_s_tdata[31:0];
    assign w_row  = i_s_tdata[39:32];
    assign w_col  = i_s_tdata[47:40];
    assign w_mag  = w_raw[31] ? (~w_raw + 32'd1) : w_raw;
    assign w_rows = (CW'(r_rows) > LIM) ? LIM : CW'(r_rows);
    assign w_cols = (CW'(r_cols) > LIM) ? LIM : CW'(r_cols);
    assign w_n    = (w_rows < w_cols) ? w_rows : w_cols;
    assign w_pass = r_sym ? ((w_row <= w_col) && (CW'(w_col) < w_n))
                          : ((CW'(w_row) < w_rows) && (CW'(w_col) < w_cols));

    assign w_out_free  = ~r_out_vld | i_m_tready;
    assign w_ce        = w_out_free | ~r_vld[LAT-1];
    assign o_s_tready  = w_ce;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel_type <= rbfk_pkg::KT_GAUSS;
            r_beta        <= 32'd65536;
            r_sym         <= 1'b0;
            r_rows        <= 9'd256;
            r_cols        <= 9'd256;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rbfk_pkg::CFG_KERNEL_TYPE: r_kernel_type <= i_cfg_data[1:0];
                rbfk_pkg::CFG_BETA:        r_beta        <= i_cfg_data;
                rbfk_pkg::CFG_SYMMETRIC:   r_sym         <= i_cfg_data[0];
                rbfk_pkg::CFG_ROWS:        r_rows        <= i_cfg_data[8:0];
                rbfk_pkg::CFG_COLS:        r_cols        <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    rbfk_gauss u_gauss (
        .i_clk    (i_clk),
        .i_ce     (w_ce),
        .i_mag    (w_mag),
        .i_beta   (r_beta),
        .o_value  (w_g_val),
        .o_status (w_g_st)
    );

    rbfk_mq u_mq (
        .i_clk    (i_clk),
        .i_ce     (w_ce),
        .i_mag    (w_mag),
        .i_beta   (r_beta),
        .o_value  (w_m_val),
        .o_status (w_m_st)
    );

    rbfk_tps u_tps (
        .i_clk    (i_clk),
        .i_ce     (w_ce),
        .i_raw    (w_raw),
        .o_value  (w_t_val),
        .o_status (w_t_st)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < LAT; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (w_ce) begin
            r_vld[0] <= i_s_tvalid & w_pass;
            for (int s = 1; s < LAT; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_row[0] <= w_row;
            r_col[0] <= w_col;
            r_raw[0] <= w_raw;
            for (int s = 1; s < LAT; s++) begin
                r_row[s] <= r_row[s-1];
                r_col[s] <= r_col[s-1];
                r_raw[s] <= r_raw[s-1];
            end
            r_gpad_val[0] <= w_g_val;
            r_gpad_st[0]  <= w_g_st;
            for (int s = 1; s < GPAD; s++) begin
                r_gpad_val[s] <= r_gpad_val[s-1];
                r_gpad_st[s]  <= r_gpad_st[s-1];
            end
            r_mpad_val[0] <= w_m_val;
            r_mpad_st[0]  <= w_m_st;
            for (int s = 1; s < MPAD; s++) begin
                r_mpad_val[s] <= r_mpad_val[s-1];
                r_mpad_st[s]  <= r_mpad_st[s-1];
            end
        end
    end

    always_comb begin
        case (r_kernel_type)
            rbfk_pkg::KT_GAUSS: begin
                w_sel_val = r_gpad_val[GPAD-1];
                w_sel_st  = r_gpad_st[GPAD-1];
            end
            rbfk_pkg::KT_MQUAD: begin
                w_sel_val = r_mpad_val[MPAD-1];
                w_sel_st  = r_mpad_st[MPAD-1];
            end
            rbfk_pkg::KT_TPS: begin
                w_sel_val = w_t_val;
                w_sel_st  = w_t_st;
            end
            default: begin
                w_sel_val = r_raw[LAT-1];
                w_sel_st  = rbfk_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_free) begin
            r_out_vld <= r_vld[LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_out_val <= w_sel_val;
            r_out_row <= r_row[LAT-1];
            r_out_col <= r_col[LAT-1];
            r_out_mir <= r_sym;
            r_out_st  <= w_sel_st;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {r_out_col, r_out_row, r_out_val};
    assign o_m_tuser  = {r_out_st, r_out_mir};

endmodule

// File: rtl/core/rbfk_checker.sv
// Port-level checks on the result stream of rbf_kernel_elementwise, with bind.
// Depends on rbfk_pkg.
module rbfk_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_m_tvalid,
    input logic                        i_m_tready,
    input logic [rbfk_pkg::DATA_W-1:0] i_m_tdata,
    input logic [rbfk_pkg::USER_W-1:0] i_m_tuser
);
    logic [1:0] w_st;
    assign w_st = i_m_tuser[2:1];

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser))
        else $error("result changed during stall");

    a_mirror: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tuser[0] |-> i_m_tdata[39:32] <= i_m_tdata[47:40])
        else $error("mirrored result below diagonal");

    a_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && (w_st == rbfk_pkg::ST_INVALID) |-> i_m_tdata[31:0] == 32'd0)
        else $error("invalid result with nonzero value");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && (w_st == rbfk_pkg::ST_ZERO) |-> i_m_tdata[31:0] == 32'd0)
        else $error("zero status with nonzero value");

    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && (w_st == rbfk_pkg::ST_SAT) |->
        (i_m_tdata[31:0] == rbfk_pkg::POS_MAX) || (i_m_tdata[31:0] == rbfk_pkg::NEG_MAX))
        else $error("saturated status without limit value");

endmodule

bind rbf_kernel_elementwise rbfk_checker u_rbfk_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata),
    .i_m_tuser  (o_m_tuser)
);
